### src/pobia_pkg.sv
// ----------------------------------------------------------------------------
// pobia_pkg
// Shared types and codes of the per-owner block id allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package pobia_pkg;
    localparam logic       REQ_ALLOC   = 1'b0;
    localparam logic       REQ_RELEASE = 1'b1;
    localparam logic [2:0] ST_NEW      = 3'd0;
    localparam logic [2:0] ST_EXIST    = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_RELEASED = 3'd4;
    localparam logic [2:0] ST_IGNORED  = 3'd5;
    localparam logic [16:0] ID_LIMIT   = 17'h0FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture request, start table read
        logic decide;   // evaluate request against read data
        logic commit;   // write tables, present result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done; // lowest-free search finished
    } t_sts;
endpackage
`default_nettype wire

### src/pobia_ram.sv
// ----------------------------------------------------------------------------
// pobia_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module pobia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### src/pobia_ctrl.sv
// ----------------------------------------------------------------------------
// pobia_ctrl
// Controller: clearing pass, request sequencing and output handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module pobia_ctrl #(
    parameter int UNIT_HANDLES = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire pobia_pkg::t_sts i_sts,
    output pobia_pkg::t_cmd    o_cmd,
    output logic               o_clr_en,
    output logic [$clog2(UNIT_HANDLES)-1:0] o_clr_addr
);
    import pobia_pkg::*;
    localparam int AW = $clog2(UNIT_HANDLES);
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_ov, n_ov;
    logic          w_acc;

    // Output beat is held in its register; a new request may start meanwhile,
    // and its commit waits until the output register is free.
    assign w_acc = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_clr_en = (r_state == S_CLR);
    assign o_clr_addr = r_clr;

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_ov = r_ov && i_out_stall;
        o_cmd = '0;
        case (r_state)
            S_CLR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(UNIT_HANDLES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.load = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.decide = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!n_ov) begin
                    o_cmd.commit = 1'b1;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_ov <= n_ov;
        end
    end
endmodule
`default_nettype wire

### src/pobia_dp.sv
// ----------------------------------------------------------------------------
// pobia_dp
// Datapath: owner registers, unit table in RAM, free-slot search, id math.
// ----------------------------------------------------------------------------
`default_nettype none
module pobia_dp #(
    parameter int MAX_OWNERS   = 16,
    parameter int MAX_SLOTS    = 256,
    parameter int UNIT_HANDLES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [8:0]  i_max_units,
    input  wire logic        i_req_type,
    input  wire logic [3:0]  i_owner,
    input  wire logic [9:0]  i_unit_handle,
    input  wire pobia_pkg::t_cmd i_cmd,
    output pobia_pkg::t_sts  o_sts,
    input  wire logic        i_clr_en,
    input  wire logic [$clog2(UNIT_HANDLES)-1:0] i_clr_addr,
    output logic [2:0]       o_status,
    output logic [15:0]      o_unit_id,
    output logic [7:0]       o_slot_index,
    output logic [3:0]       o_unit_owner,
    output logic [8:0]       o_owner_used
);
    import pobia_pkg::*;
    localparam int AW = $clog2(UNIT_HANDLES);
    localparam int OW = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int BW = $clog2(MAX_OWNERS + 1);
    localparam int GROUPS = (MAX_SLOTS + 31) / 32;
    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    // Table word: holds, owner, slot, id.
    localparam int TW = 1 + 4 + 8 + 16;

    logic            r_has  [MAX_OWNERS];
    logic [BW-1:0]   r_bnum [MAX_OWNERS];
    logic [BW-1:0]   r_given;
    logic [CW-1:0]   r_next [MAX_OWNERS];
    logic [CW-1:0]   r_used [MAX_OWNERS];
    logic [MAX_SLOTS-1:0] r_free [MAX_OWNERS];

    logic            r_rt;
    logic [3:0]      r_own;
    logic [9:0]      r_u;
    logic            r_uok, r_ook;
    logic [8:0]      r_m;
    logic [OW-1:0]   r_oi;

    logic [TW-1:0]   w_rdata, w_wdata;
    logic            w_we;
    logic [AW-1:0]   w_addr;

    // Decide-phase registers.
    logic            r_held;
    logic [TW-1:0]   r_ent;
    logic [BW-1:0]   r_bn;
    logic            r_newblk;
    logic            r_rangeok;
    logic [16:0]     r_prod;
    logic [MAX_SLOTS-1:0] r_fm;
    logic [GW-1:0]   r_grp;
    logic            r_found, r_scan;
    logic [SW-1:0]   r_fs;

    logic [2:0]  r_st;
    logic [15:0] r_id;
    logic [7:0]  r_sl;
    logic [3:0]  r_ow;
    logic [8:0]  r_us;

    // The table read starts on the accepting edge so its data is ready for the decide.
    assign w_addr = i_clr_en ? i_clr_addr
                  : (i_cmd.load ? i_unit_handle[AW-1:0] : r_u[AW-1:0]);

    pobia_ram #(.WIDTH(TW), .DEPTH(UNIT_HANDLES)) u_tab (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    // Fields of the read entry.
    logic [3:0]    w_eo;
    logic [7:0]    w_es;
    logic [15:0]   w_ei;
    assign {w_eo, w_es, w_ei} = r_ent[TW-2:0];

    logic [OW-1:0] w_eoi;
    logic          w_eook;
    assign w_eoi  = OW'(w_eo);
    assign w_eook = (32'(w_eo) < MAX_OWNERS);

    // One 32-bit group of the freed map per scan cycle.
    logic [31:0] w_gv;
    logic [4:0]  w_bit;
    logic        w_gnz;
    always_comb begin
        w_gv = '0;
        for (int b = 0; b < 32; b++) begin
            if (32'(r_grp) * 32 + b < MAX_SLOTS) begin
                w_gv[b] = r_fm[(32'(r_grp) * 32 + b) % MAX_SLOTS];
            end
        end
        w_gnz = (w_gv != '0);
        w_bit = '0;
        for (int b = 31; b >= 0; b--) begin
            if (w_gv[b]) begin
                w_bit = 5'(b);
            end
        end
    end

    // Commit-time result and writes.
    logic [2:0]  w_st;
    logic [15:0] w_id;
    logic [7:0]  w_sl;
    logic [3:0]  w_ow;
    logic [8:0]  w_us;
    logic [SW-1:0] w_slot;
    logic        w_take, w_fresh, w_rel;
    logic [CW-1:0] w_cnt;
    logic [16:0] w_idsum;

    always_comb begin
        w_st = ST_IGNORED; w_id = '0; w_sl = '0; w_ow = '0; w_us = '0;
        w_take = 1'b0; w_fresh = 1'b0; w_rel = 1'b0;
        w_slot = r_found ? r_fs : SW'(r_next[r_oi]);
        w_cnt = r_used[r_oi] + 1'b1;
        w_idsum = r_prod + 17'(w_slot) + 17'd1;
        if (r_rt == REQ_RELEASE) begin
            if (r_held) begin
                w_rel = 1'b1;
                w_st = ST_RELEASED; w_id = w_ei; w_sl = w_es; w_ow = w_eo;
                if (w_eook && r_has[w_eoi]) begin
                    w_us = 9'((r_used[w_eoi] != '0) ? r_used[w_eoi] - 1'b1
                                                    : r_used[w_eoi]);
                end
            end
        end else if (r_held) begin
            w_st = ST_EXIST; w_id = w_ei; w_sl = w_es; w_ow = w_eo;
            if (w_eook && r_has[w_eoi]) w_us = 9'(r_used[w_eoi]);
        end else if (!r_uok || !r_ook || r_m == '0) begin
            w_st = ST_RANGE;
            if (r_ook && r_has[r_oi]) w_us = 9'(r_used[r_oi]);
        end else if (!r_rangeok) begin
            w_st = ST_RANGE; w_us = 9'(r_used[r_oi]);
        end else if (!r_found && 9'(r_next[r_oi]) >= r_m) begin
            w_st = ST_FULL; w_us = 9'(r_used[r_oi]);
        end else begin
            w_take = 1'b1; w_fresh = !r_found;
            w_st = ST_NEW; w_id = w_idsum[15:0]; w_sl = 8'(w_slot);
            w_ow = r_own; w_us = 9'(w_cnt);
        end
    end

    assign w_we = i_clr_en || (i_cmd.commit && (w_take || w_rel));
    assign w_wdata = (i_clr_en || w_rel) ? '0
                   : {1'b1, r_own, 8'(w_slot), w_idsum[15:0]};
    assign o_sts.scan_done = !r_scan;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rt  <= i_req_type;
            r_own <= i_owner;
            r_u   <= i_unit_handle;
            r_uok <= (32'(i_unit_handle) < UNIT_HANDLES);
            r_ook <= (32'(i_owner) < MAX_OWNERS);
            r_oi  <= OW'(i_owner);
            r_m   <= (32'(i_max_units) > MAX_SLOTS) ? 9'(MAX_SLOTS) : i_max_units;
        end
        if (i_cmd.decide) begin
            r_ent  <= w_rdata;
            r_held <= r_uok && w_rdata[TW-1];
            r_newblk <= !r_has[r_oi];
            r_bn   <= r_has[r_oi] ? r_bnum[r_oi] : r_given;
            r_prod <= 17'((r_has[r_oi] ? r_bnum[r_oi] : r_given) * r_m);
            r_rangeok <= (18'((r_has[r_oi] ? r_bnum[r_oi] : r_given) + 1'b1)
                          * 18'(r_m)) <= 18'(ID_LIMIT);
            r_fm   <= r_free[r_oi];
            r_grp  <= '0;
            r_found <= 1'b0;
            r_fs   <= '0;
        end else if (r_scan) begin
            if (w_gnz) begin
                r_found <= 1'b1;
                r_fs <= SW'(32'(r_grp) * 32 + 32'(w_bit));
            end
            r_grp <= r_grp + 1'b1;
        end
        if (i_cmd.commit) begin
            r_st <= w_st; r_id <= w_id; r_sl <= w_sl; r_ow <= w_ow; r_us <= w_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= 1'b0;
        end else if (i_cmd.decide) begin
            r_scan <= 1'b1;
        end else if (r_scan && (w_gnz || 32'(r_grp) == GROUPS - 1)) begin
            r_scan <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_given <= '0;
            for (int o = 0; o < MAX_OWNERS; o++) begin
                r_has[o] <= 1'b0; r_bnum[o] <= '0; r_next[o] <= '0;
                r_used[o] <= '0; r_free[o] <= '0;
            end
        end else if (i_cmd.commit && r_rt == REQ_ALLOC && !r_held) begin
            if (r_uok && r_ook && r_m != '0 && r_newblk) begin
                r_has[r_oi] <= 1'b1;
                r_bnum[r_oi] <= r_bn;
                r_given <= r_given + 1'b1;
            end
            if (w_take) begin
                r_used[r_oi] <= w_cnt;
                if (w_fresh) r_next[r_oi] <= r_next[r_oi] + 1'b1;
                else r_free[r_oi][w_slot] <= 1'b0;
            end
        end else if (i_cmd.commit && w_rel && w_eook && r_has[w_eoi]) begin
            if (32'(w_es) < MAX_SLOTS) r_free[w_eoi][SW'(w_es)] <= 1'b1;
            if (r_used[w_eoi] != '0) r_used[w_eoi] <= r_used[w_eoi] - 1'b1;
        end
    end

    assign o_status = r_st;
    assign o_unit_id = r_id;
    assign o_slot_index = r_sl;
    assign o_unit_owner = r_ow;
    assign o_owner_used = r_us;
endmodule
`default_nettype wire

### src/per_owner_block_id_allocator.sv
// ----------------------------------------------------------------------------
// per_owner_block_id_allocator
// Gives units ids inside per-owner blocks and takes them back on release.
// ----------------------------------------------------------------------------
// A request beat (i_req_type, i_owner, i_unit_handle) is taken when
// i_in_valid is high and o_in_stall is low. Each request yields one result
// beat on o_out_valid, held until i_out_stall is low.
// The result is registered after the unit table is read, the request is
// decided and the freed-slot map is searched one 32-slot group at a time;
// the search stops at the first group with a freed slot, and with no freed
// slot all groups are searched. The next request can be accepted in the
// cycle after the result is registered. The unit table is one RAM
// port, read then written back.
// After reset a clearing pass zeroes the unit table; no request is taken
// during it. max_units resets to 256; the user must write it, through
// i_cfg_we / i_cfg_data, only while the block is idle; it is not enforced.
// While the receiver stalls, the result waits in its register and the next
// request is processed up to its commit.
// ----------------------------------------------------------------------------
`default_nettype none
module per_owner_block_id_allocator #(
    parameter int MAX_OWNERS   = 16,
    parameter int MAX_SLOTS    = 256,
    parameter int UNIT_HANDLES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [8:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [3:0]  i_owner,
    input  wire logic [9:0]  i_unit_handle,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [15:0]      o_unit_id,
    output logic [7:0]       o_slot_index,
    output logic [3:0]       o_unit_owner,
    output logic [8:0]       o_owner_used
);
    import pobia_pkg::*;
    logic [8:0] r_max_units;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_clr_en;
    logic [$clog2(UNIT_HANDLES)-1:0] w_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= 9'd256;
        end else if (i_cfg_we) begin
            r_max_units <= i_cfg_data;
        end
    end

    pobia_ctrl #(.UNIT_HANDLES(UNIT_HANDLES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_sts(w_sts), .o_cmd(w_cmd),
        .o_clr_en(w_clr_en), .o_clr_addr(w_clr_addr)
    );

    pobia_dp #(
        .MAX_OWNERS(MAX_OWNERS), .MAX_SLOTS(MAX_SLOTS), .UNIT_HANDLES(UNIT_HANDLES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_max_units(r_max_units),
        .i_req_type(i_req_type), .i_owner(i_owner), .i_unit_handle(i_unit_handle),
        .i_cmd(w_cmd), .o_sts(w_sts),
        .i_clr_en(w_clr_en), .i_clr_addr(w_clr_addr),
        .o_status(o_status), .o_unit_id(o_unit_id), .o_slot_index(o_slot_index),
        .o_unit_owner(o_unit_owner), .o_owner_used(o_owner_used)
    );
endmodule
`default_nettype wire
